FILE: rtl/voxel_ray_traversal_unit_assert.svh
// ----------------------------------------------------------------------------
// Voxel ray traversal unit assertion macros
// Clocked assertion helpers for the traversal unit. They expect i_clk and
// i_rst_n in scope, and they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_UNIT_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define VRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("voxel ray traversal assertion failed");
// Next-cycle implication.
`define VRT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("voxel ray traversal assertion failed");
`else
`define VRT_ASSERT_IMP(lbl, ante, cons)
`define VRT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal package
// Widths, codes, queue entry type and saturation helper shared by the unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIST_BITS  = 32;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    // Divider operand widths: dividend up to 256 * (2^32 - 1), divisor up to 2^23.
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 24;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [DIST_BITS-1:0]  t_dist;

    localparam t_dist DMAX = {DIST_BITS{1'b1}};

    // Result kinds.
    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    // Entry faces.
    localparam logic [2:0] FACE_NONE  = 3'd0;
    localparam logic [2:0] FACE_SOUTH = 3'd6;

    // Request classes decided by the front end.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ZERO   = 2'd1;
    localparam logic [1:0] OP_ANSWER = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [31:0]        reach_dist;
        logic               probe_hit;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Clamp a wide distance to the all-ones distance.
    function automatic t_dist sat_dist(logic [DIV_NUM_W-1:0] v);
        t_dist res;
        if (DIST_BITS < DIV_NUM_W && v > DIV_NUM_W'(DMAX)) begin
            res = DMAX;
        end else begin
            res = DIST_BITS'(v);
        end
        return res;
    endfunction

endpackage

FILE: rtl/vrt_if.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal channel interfaces
// Valid/ready channels for input requests and result requests.
// ----------------------------------------------------------------------------
interface vrt_req_if;
    import vrt_pkg::*;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [31:0]        reach_dist;
    logic               probe_hit;

    modport source (output valid, mode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    reach_dist, probe_hit, input ready);
    modport sink (input valid, mode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  reach_dist, probe_hit, output ready);
endinterface

interface vrt_rsp_if;
    import vrt_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic signed [COORD_BITS-1:0] cell_x;
    logic signed [COORD_BITS-1:0] cell_y;
    logic signed [COORD_BITS-1:0] cell_z;
    logic [2:0]                  entry_face;

    modport source (output valid, kind, cell_x, cell_y, cell_z, entry_face, input ready);
    modport sink (input valid, kind, cell_x, cell_y, cell_z, entry_face, output ready);
endinterface

FILE: rtl/vrt_front.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal front end
// Accepts input requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module vrt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vrt_req_if.sink          i_req,
    output vrt_pkg::t_q_head o_head,
    input  logic             i_pop
);
    import vrt_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              n_cmd;
    logic              push;
    logic              pop;

    // Classify the incoming request.
    always_comb begin
        n_cmd            = '0;
        n_cmd.origin_x   = i_req.origin_x;
        n_cmd.origin_y   = i_req.origin_y;
        n_cmd.origin_z   = i_req.origin_z;
        n_cmd.dir_x      = i_req.dir_x;
        n_cmd.dir_y      = i_req.dir_y;
        n_cmd.dir_z      = i_req.dir_z;
        n_cmd.reach_dist = i_req.reach_dist;
        n_cmd.probe_hit  = i_req.probe_hit;
        if (i_req.mode) begin
            n_cmd.op = OP_ANSWER;
        end else if (i_req.dir_x == '0 && i_req.dir_y == '0 && i_req.dir_z == '0) begin
            n_cmd.op = OP_ZERO;
        end else begin
            n_cmd.op = OP_START;
        end
    end

    assign i_req.ready  = (r_cnt != QCNT_W'(QDEPTH));
    assign push         = i_req.valid && i_req.ready;
    assign pop          = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_slot[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= n_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/vrt_isqrt.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal square root
// Bit-serial integer square root of S * 2^32, one root bit per cycle.
// ----------------------------------------------------------------------------
module vrt_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    import vrt_pkg::*;

    logic [63:0] r_n;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [63:0] trial;

    assign trial  = r_r + r_bit;
    assign o_done = r_done;
    assign o_root = r_r[31:0];

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_bit == 64'd1);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_bit == 64'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // One restoring step per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= {i_rad, 32'd0};
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n <= r_n - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

FILE: rtl/vrt_div.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [vrt_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [vrt_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [vrt_pkg::DIV_NUM_W-1:0]  o_quot
);
    import vrt_pkg::*;

    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    assign trial  = {r_rem, r_q[DIV_NUM_W-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_q;

    // Iteration count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Shift-subtract datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : DIV_DEN_W'(trial);
            r_q   <= {r_q[DIV_NUM_W-2:0], ge};
        end
    end

endmodule

FILE: rtl/vrt_back.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal back end
// Sets up a ray with the shared root and divide units, walks the grid one
// cell per answer and holds the result in an output register.
// ----------------------------------------------------------------------------
module vrt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vrt_pkg::t_q_head i_head,
    output logic             o_pop,
    vrt_rsp_if.source        o_rsp
);
    import vrt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_AXIS = 3'd3;
    localparam logic [2:0] S_DIV1 = 3'd4;
    localparam logic [2:0] S_DIV2 = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_STEP = 3'd7;

    logic [2:0]  r_state;
    logic        r_active;
    t_coord      r_cell [3];
    logic        r_pos [3];
    t_dist       r_nb [3];
    t_dist       r_dl [3];
    t_dist       r_lim;
    logic [2:0]  r_face;
    logic [15:0] r_mag [3];
    logic [8:0]  r_gap [3];
    logic [31:0] r_sq [3];
    logic [31:0] r_len;
    logic [1:0]  r_ax;
    logic [DIV_NUM_W-1:0] r_prod;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    t_coord      r_out_cell [3];
    logic [2:0]  r_out_face;

    logic        out_free;
    t_cmd        cmd;
    logic signed [31:0] org [3];
    logic signed [15:0] dir [3];
    logic        sq_start;
    logic        sq_done;
    logic [31:0] sq_root;
    logic        div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic        div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [1:0]  near_ax;
    t_coord      step_cell;
    logic [DIST_BITS:0] nb_sum;
    t_dist       step_nb;
    logic [2:0]  step_face;

    assign cmd      = i_head.cmd;
    assign org[0]   = cmd.origin_x;
    assign org[1]   = cmd.origin_y;
    assign org[2]   = cmd.origin_z;
    assign dir[0]   = cmd.dir_x;
    assign dir[1]   = cmd.dir_y;
    assign dir[2]   = cmd.dir_z;
    assign out_free = !r_out_valid || o_rsp.ready;

    // Take the head request when it can be carried out now.
    assign o_pop = i_head.valid && (r_state == S_IDLE)
                   && (out_free || cmd.op == OP_START
                       || (cmd.op == OP_ANSWER && !(r_active && cmd.probe_hit)));

    // Axis with the nearest boundary; ties go to the later axis: z over y, y over x.
    always_comb begin
        if (r_nb[0] < r_nb[1]) begin
            near_ax = (r_nb[0] < r_nb[2]) ? 2'd0 : 2'd2;
        end else begin
            near_ax = (r_nb[1] < r_nb[2]) ? 2'd1 : 2'd2;
        end
    end

    // One cell step along the chosen axis.
    always_comb begin
        step_cell = r_pos[r_ax] ? r_cell[r_ax] + 1'b1 : r_cell[r_ax] - 1'b1;
        nb_sum    = {1'b0, r_nb[r_ax]} + {1'b0, r_dl[r_ax]};
        step_nb   = nb_sum[DIST_BITS] ? DMAX : nb_sum[DIST_BITS-1:0];
        step_face = {r_ax, 1'b0} + 3'd1 + {2'b0, ~r_pos[r_ax]};
    end

    // Shared unit hookup.
    assign sq_start  = (r_state == S_SUM);
    assign div_start = (r_state == S_AXIS && r_mag[r_ax] != '0)
                       || (r_state == S_DIV1 && div_done);
    always_comb begin
        if (r_state == S_AXIS) begin
            div_num = DIV_NUM_W'(r_len);
            div_den = DIV_DEN_W'(r_mag[r_ax]);
        end else begin
            div_num = r_prod;
            div_den = DIV_DEN_W'({r_mag[r_ax], 8'd0});
        end
    end

    vrt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_sq[0] + r_sq[1] + r_sq[2]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    vrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (cmd.op)
                            OP_START: begin
                                r_active <= 1'b0;
                                r_state  <= S_SUM;
                            end
                            OP_ZERO: begin
                                r_active    <= 1'b0;
                                r_out_valid <= 1'b1;
                            end
                            OP_ANSWER: begin
                                if (r_active && cmd.probe_hit) begin
                                    r_active    <= 1'b0;
                                    r_out_valid <= 1'b1;
                                end else if (r_active) begin
                                    r_state <= S_STEP;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_AXIS;
                    end
                end
                S_AXIS: begin
                    if (r_mag[r_ax] != '0) begin
                        r_state <= S_DIV1;
                    end else if (r_ax == 2'd2) begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_state <= (r_ax == 2'd2) ? S_EMIT : S_AXIS;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_active    <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_STEP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_nb[r_ax] > r_lim) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Ray datapath and result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= '0;
                r_pos[a]  <= 1'b0;
                r_nb[a]   <= '0;
                r_dl[a]   <= '0;
            end
            r_lim  <= '0;
            r_face <= FACE_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && cmd.op == OP_START) begin
                        for (int a = 0; a < 3; a++) begin
                            logic signed [32:0] v;
                            logic signed [24:0] c;
                            v          = {org[a][31], org[a]} + 33'sd128;
                            c          = v[32:8];
                            r_cell[a] <= COORD_BITS'(c);
                            r_pos[a]  <= !dir[a][15] && (dir[a] != '0);
                            r_mag[a]  <= dir[a][15] ? 16'(-dir[a]) : 16'(dir[a]);
                            r_gap[a]  <= (!dir[a][15] && dir[a] != '0)
                                         ? 9'd256 - {1'b0, v[7:0]} : {1'b0, v[7:0]};
                            r_sq[a]   <= 32'(dir[a] * dir[a]);
                        end
                        r_lim  <= sat_dist(DIV_NUM_W'(cmd.reach_dist));
                        r_face <= FACE_NONE;
                    end
                    if (o_pop && (cmd.op == OP_ZERO
                                  || (cmd.op == OP_ANSWER && r_active && cmd.probe_hit))) begin
                        r_out_kind <= (cmd.op == OP_ZERO) ? KIND_MISS : KIND_HIT;
                        for (int a = 0; a < 3; a++) begin
                            r_out_cell[a] <= (cmd.op == OP_ZERO) ? '0 : r_cell[a];
                        end
                        r_out_face <= (cmd.op == OP_ZERO) ? FACE_NONE : r_face;
                    end
                    if (o_pop && cmd.op == OP_ANSWER) begin
                        r_ax <= near_ax;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_len <= sq_root;
                        r_ax  <= 2'd0;
                    end
                end
                S_AXIS: begin
                    if (r_mag[r_ax] == '0) begin
                        r_dl[r_ax] <= DMAX;
                        r_nb[r_ax] <= DMAX;
                        r_ax       <= r_ax + 1'b1;
                    end else begin
                        r_prod <= DIV_NUM_W'(r_gap[r_ax] * r_len);
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_dl[r_ax] <= sat_dist(div_quot);
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_nb[r_ax] <= sat_dist(div_quot);
                        r_ax       <= r_ax + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_kind <= KIND_PROBE;
                        for (int a = 0; a < 3; a++) begin
                            r_out_cell[a] <= r_cell[a];
                        end
                        r_out_face <= FACE_NONE;
                    end
                end
                S_STEP: begin
                    if (out_free) begin
                        r_cell[r_ax] <= step_cell;
                        r_nb[r_ax]   <= step_nb;
                        r_face       <= step_face;
                        if (r_nb[r_ax] > r_lim) begin
                            r_out_kind <= KIND_MISS;
                            for (int a = 0; a < 3; a++) begin
                                r_out_cell[a] <= '0;
                            end
                            r_out_face <= FACE_NONE;
                        end else begin
                            r_out_kind <= KIND_PROBE;
                            for (int a = 0; a < 3; a++) begin
                                r_out_cell[a] <= (2'(a) == r_ax) ? step_cell : r_cell[a];
                            end
                            r_out_face <= step_face;
                        end
                    end
                end
                default: begin
                    r_face <= r_face;
                end
            endcase
        end
    end

    // Result channel.
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.kind       = r_out_kind;
    assign o_rsp.cell_x     = r_out_cell[0];
    assign o_rsp.cell_y     = r_out_cell[1];
    assign o_rsp.cell_z     = r_out_cell[2];
    assign o_rsp.entry_face = r_out_face;

endmodule

FILE: rtl/voxel_ray_traversal_unit.sv
// ----------------------------------------------------------------------------
// Voxel ray traversal unit
// Walks a ray through a 3D grid of unit cells, probing one cell at a time.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_req (valid/ready). A start request (mode 0)
// carries origin, direction and reach; it yields one probe result for the
// start cell, or a miss at once for a zero direction. Each answer request
// (mode 1) reports whether the last probed cell is solid and yields either a
// hit, a probe of the next cell, or a miss once the reach is passed. Answers
// with no ray in flight produce nothing. Results leave on o_rsp (valid/ready).
// A two-entry queue takes requests while the walker is busy, and the result
// register frees the walker as soon as o_rsp takes the result.
// A hit answer goes from the queue head straight to the result register; an
// answer that steps passes the step state, waiting there while that register
// is full. A start runs a 32-step square root and up to six 40-step divisions
// on one shared divider. No request is taken while a start or step is underway.
// Reset clears the queue, drops any ray and empties the result register.
// When o_rsp stalls, the walker holds its next result and the queue fills.
// ----------------------------------------------------------------------------
`include "voxel_ray_traversal_unit_assert.svh"
module voxel_ray_traversal_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    vrt_req_if.sink   i_req,
    vrt_rsp_if.source o_rsp
);
    import vrt_pkg::*;

    t_q_head q_head;
    logic    q_pop;

    vrt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    vrt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_rsp   (o_rsp)
    );

    // A miss carries no cell and no face.
    `VRT_ASSERT_IMP(a_miss_clear, o_rsp.valid && o_rsp.kind == KIND_MISS, o_rsp.cell_x == '0 && o_rsp.cell_y == '0 && o_rsp.cell_z == '0 && o_rsp.entry_face == FACE_NONE)
    // Faces stay within the six cube faces.
    `VRT_ASSERT_IMP(a_face_range, o_rsp.valid, o_rsp.entry_face <= FACE_SOUTH)
    // A queued request is not lost until it is taken.
    `VRT_ASSERT_NXT(a_queue_keep, q_head.valid && !q_pop, q_head.valid)

endmodule
